>>> design/aekd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aekd_pkg
// Shared constants, result type and final-byte lookup for the terminal key
// decoder.
// ----------------------------------------------------------------------------
package aekd_pkg;

   localparam logic [7:0] BYTE_ESC  = 8'h1B;
   localparam logic [7:0] BYTE_DEL  = 8'h7F;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_LF   = 8'h0A;
   localparam logic [7:0] BYTE_BS   = 8'h08;
   localparam logic [7:0] BYTE_LBRK = 8'h5B;  // '['
   localparam logic [7:0] BYTE_SS3  = 8'h4F;  // 'O'
   localparam logic [7:0] BYTE_SEMI = 8'h3B;  // ';'
   localparam logic [7:0] BYTE_TILDE = 8'h7E; // '~'
   localparam logic [7:0] BYTE_ZERO = 8'h30;
   localparam logic [7:0] BYTE_NINE = 8'h39;
   localparam logic [7:0] BYTE_A    = 8'h41;
   localparam logic [7:0] BYTE_B    = 8'h42;
   localparam logic [7:0] BYTE_C    = 8'h43;
   localparam logic [7:0] BYTE_D    = 8'h44;
   localparam logic [7:0] BYTE_F    = 8'h46;
   localparam logic [7:0] BYTE_H    = 8'h48;

   localparam int unsigned PARAM_W = 10;
   localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd999;

   // result queue: depth is a power of two so the pointers wrap on their own
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   localparam logic [7:0] K_UP     = 8'd0;
   localparam logic [7:0] K_DOWN   = 8'd1;
   localparam logic [7:0] K_RIGHT  = 8'd2;
   localparam logic [7:0] K_LEFT   = 8'd3;
   localparam logic [7:0] K_HOME   = 8'd4;
   localparam logic [7:0] K_END    = 8'd5;
   localparam logic [7:0] K_DELETE = 8'd6;
   localparam logic [7:0] K_ESC    = 8'd7;
   localparam logic [7:0] K_F1     = 8'd8;
   localparam logic [7:0] K_NONE   = 8'hFF;

   typedef struct packed {
      logic       is_special;
      logic [7:0] code;
      logic       last_of_run;
   } result_type;

   // key selected by a sequence's final byte and its numeric parameter
   function automatic logic [7:0] final_key(input logic [7:0] fin,
                                            input logic [PARAM_W-1:0] n);
      logic [7:0] key;
      key = K_NONE;
      if (fin == BYTE_TILDE) begin
         case (n)
            10'd1, 10'd7:  key = K_HOME;
            10'd4, 10'd8:  key = K_END;
            10'd3:         key = K_DELETE;
            10'd11:        key = K_F1;
            10'd12:        key = K_F1 + 8'd1;
            10'd13:        key = K_F1 + 8'd2;
            10'd14:        key = K_F1 + 8'd3;
            10'd15:        key = K_F1 + 8'd4;
            10'd17:        key = K_F1 + 8'd5;
            10'd18:        key = K_F1 + 8'd6;
            10'd19:        key = K_F1 + 8'd7;
            10'd20:        key = K_F1 + 8'd8;
            10'd21:        key = K_F1 + 8'd9;
            10'd23:        key = K_F1 + 8'd10;
            10'd24:        key = K_F1 + 8'd11;
            default:       key = K_NONE;
         endcase
      end else begin
         case (fin)
            BYTE_A:  key = K_UP;
            BYTE_B:  key = K_DOWN;
            BYTE_C:  key = K_RIGHT;
            BYTE_D:  key = K_LEFT;
            BYTE_H:  key = K_HOME;
            BYTE_F:  key = K_END;
            default: key = K_NONE;
         endcase
      end
      return key;
   endfunction

endpackage
`default_nettype wire

>>> design/ansi_escape_key_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_escape_key_decoder_top
// Decodes received terminal bytes (VT100/ANSI escape sequences) into keys.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one received byte per item (req_rx_byte).
//   rsp channel carries key results: plain byte or special key code, with
//   rsp_last_of_run marking the final result caused by one input byte.
//   A byte gives zero, one or two results (esc key followed by a byte).
// Path: a byte accepted into the input register is decoded from there and
//   its results are written together into the result queue, which shows
//   them on rsp in order.
// Throughput: one byte per cycle while results are taken; bytes that give
//   two results send both through the single-result output port, so the
//   output port sets the sustained rate (one result per cycle).
// Stall: results collect in a four-entry result queue; the input register
//   holds its byte while the queue lacks room for two results, and req_ready
//   drops once the input register is full and cannot drain.
// Reset: synchronous, active high; clears the decode mode to normal, the
//   numeric parameter, the input register and the result queue.
// ----------------------------------------------------------------------------
module ansi_escape_key_decoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_is_special,
   output logic [7:0]      rsp_code,
   output logic            rsp_last_of_run
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_CSI    = 3'd2,
      MODE_SS3    = 3'd3,
      MODE_NUM    = 3'd4
   } mode_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // decoder state
   mode_type                        mode_ff, mode_in;
   logic [aekd_pkg::PARAM_W-1:0]    param_ff, param_in;

   // result queue
   aekd_pkg::result_type q_mem [aekd_pkg::QDEPTH];
   logic [aekd_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [aekd_pkg::QCNT_W-1:0] count_ff, count_in;

   logic drain, pop;
   logic [aekd_pkg::QPTR_W-1:0] push_n;
   aekd_pkg::result_type r0, r1;

   logic       digit;
   logic [3:0] digit_val;
   logic [13:0] acc;
   logic [7:0] key;
   logic [7:0] plain;

   assign drain     = in_valid_ff &&
                      (count_ff <= aekd_pkg::QCNT_W'(aekd_pkg::QDEPTH - 2));
   assign req_ready = !in_valid_ff || drain;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !drain);

   assign rsp_valid       = (count_ff != '0);
   assign pop             = rsp_valid && rsp_ready;
   assign rsp_is_special  = q_mem[rd_ptr_ff].is_special;
   assign rsp_code        = q_mem[rd_ptr_ff].code;
   assign rsp_last_of_run = q_mem[rd_ptr_ff].last_of_run;

   assign digit     = (in_byte_ff >= aekd_pkg::BYTE_ZERO) && (in_byte_ff <= aekd_pkg::BYTE_NINE);
   assign digit_val = in_byte_ff[3:0];
   assign acc = ({4'd0, param_ff} << 3) + ({4'd0, param_ff} << 1) + {10'd0, digit_val};

   always_comb begin
      key = 8'd0;
      case (mode_ff)
         MODE_NUM: key = aekd_pkg::final_key(in_byte_ff, param_ff);
         default:  key = aekd_pkg::final_key(in_byte_ff, '0);
      endcase
   end

   // normal-mode translation of a plain byte
   always_comb begin
      if (in_byte_ff == aekd_pkg::BYTE_CR) begin
         plain = aekd_pkg::BYTE_LF;
      end else if (in_byte_ff == aekd_pkg::BYTE_DEL) begin
         plain = aekd_pkg::BYTE_BS;
      end else begin
         plain = in_byte_ff;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      param_in = param_ff;
      push_n   = '0;
      r0 = '{is_special: 1'b0, code: plain, last_of_run: 1'b1};
      r1 = '{is_special: 1'b0, code: plain, last_of_run: 1'b1};
      case (mode_ff)
         MODE_ESC: begin
            if (in_byte_ff == aekd_pkg::BYTE_LBRK) begin
               mode_in  = MODE_CSI;
               param_in = '0;
            end else if (in_byte_ff == aekd_pkg::BYTE_SS3) begin
               mode_in = MODE_SS3;
            end else if (in_byte_ff == aekd_pkg::BYTE_ESC) begin
               push_n = aekd_pkg::QPTR_W'(1);
               r0     = '{is_special: 1'b1, code: aekd_pkg::K_ESC, last_of_run: 1'b1};
            end else begin
               // esc key, then the byte as in normal mode
               push_n  = aekd_pkg::QPTR_W'(2);
               mode_in = MODE_NORMAL;
               r0      = '{is_special: 1'b1, code: aekd_pkg::K_ESC, last_of_run: 1'b0};
            end
         end
         MODE_CSI, MODE_SS3, MODE_NUM: begin
            if (digit && (mode_ff == MODE_CSI)) begin
               mode_in  = MODE_NUM;
               param_in = aekd_pkg::PARAM_W'(digit_val);
            end else if (digit && (mode_ff == MODE_NUM)) begin
               param_in = (acc > 14'(aekd_pkg::PARAM_MAX)) ? aekd_pkg::PARAM_MAX
                                                           : acc[aekd_pkg::PARAM_W-1:0];
            end else if ((in_byte_ff == aekd_pkg::BYTE_SEMI) && (mode_ff == MODE_NUM)) begin
               // separator ignored, parameter keeps accumulating
            end else begin
               mode_in  = MODE_NORMAL;
               param_in = '0;
               if (key != aekd_pkg::K_NONE) begin
                  push_n = aekd_pkg::QPTR_W'(1);
                  r0     = '{is_special: 1'b1, code: key, last_of_run: 1'b1};
               end
            end
         end
         default: begin
            if (in_byte_ff == aekd_pkg::BYTE_ESC) begin
               mode_in = MODE_ESC;
            end else begin
               mode_in = MODE_NORMAL;
               push_n  = aekd_pkg::QPTR_W'(1);
            end
         end
      endcase
   end

   assign count_in = count_ff + (drain ? aekd_pkg::QCNT_W'(push_n) : '0)
                     - aekd_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         param_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + aekd_pkg::QPTR_W'(1);
         end
         if (drain) begin
            mode_ff   <= mode_in;
            param_ff  <= param_in;
            wr_ptr_ff <= wr_ptr_ff + push_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (drain && (push_n != '0)) begin
         q_mem[wr_ptr_ff] <= r0;
      end
      if (drain && (push_n == aekd_pkg::QPTR_W'(2))) begin
         q_mem[wr_ptr_ff + aekd_pkg::QPTR_W'(1)] <= r1;
      end
   end

   // queue occupancy never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= aekd_pkg::QCNT_W'(aekd_pkg::QDEPTH))
      else $error("result queue overflow");

   // parameter stays within the clamp
   assert property (@(posedge clock) disable iff (reset) param_ff <= aekd_pkg::PARAM_MAX)
      else $error("csi parameter beyond clamp");

   // parameter is cleared whenever the decoder is back in normal mode
   assert property (@(posedge clock) disable iff (reset)
                    (mode_ff == MODE_NORMAL) |-> (param_ff == '0))
      else $error("parameter not cleared in normal mode");

   // a queue that cannot take two results holds the pending byte
   assert property (@(posedge clock) disable iff (reset)
                    (in_valid_ff && (count_ff > aekd_pkg::QCNT_W'(aekd_pkg::QDEPTH - 2)))
                    |=> in_valid_ff)
      else $error("input byte dropped while queue full");

endmodule
`default_nettype wire
